// ===== sv/apset_pkg.sv =====
// Package for the answered pair set: shared sizes, action codes and FSM state type.
// Used by answered_pair_set_top.sv; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package apset_pkg;

  localparam int SOURCES     = 256;
  localparam int SET_DEPTH   = 64;
  localparam int ABSENT_MARK = 65535;
  localparam int ITEM_W      = 16;
  localparam int SOURCE_W    = 16;

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_ANSWER = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHOWN = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== sv/answered_pair_set_top.sv =====
// Top level of the answered pair set: shown-item table and append-only key set.
// Depends on apset_pkg.sv and apset_ram.sv.
//
// Channel   Direction  Signals                 Transfer condition
// -------   ---------  ----------------------  -----------------------------
// command   in         action, source, item    start high and busy low
// result    out        flag                    done high (one cycle only)
//
// Record and clear finish from idle: the result strobes in the cycle after the transfer and busy
// never rises. A query scans the stored keys; an answer first checks its shown entry, then scans:
// the key memory's single read port delivers one key per cycle, each key is compared in the cycle
// after its read, and the scan ends on a hit or once no read is pending, then the strobe follows.
// Out-of-range sources finish from idle with flag low. Synchronous reset empties the set and
// marks every shown entry absent at once through one valid bit per source; nothing stalls.
`timescale 1ns / 1ps
`default_nettype none

module answered_pair_set_top #(
  parameter int SOURCES     = apset_pkg::SOURCES,
  parameter int SET_DEPTH   = apset_pkg::SET_DEPTH,
  parameter int ABSENT_MARK = apset_pkg::ABSENT_MARK
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] source,
  input  wire logic [15:0] item,
  output logic             done,
  output logic             flag
);

  // Width of a source row index, of a key, of a set address and of the fill count.
  localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int ITEM_W = apset_pkg::ITEM_W;
  localparam int KEY_W  = SRC_W + ITEM_W;
  localparam int SET_AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SET_DEPTH + 1);

  localparam logic [ITEM_W-1:0] ABSENT = ITEM_W'(ABSENT_MARK);
  localparam logic [CNT_W-1:0]  FULL   = CNT_W'(SET_DEPTH);

  apset_pkg::state_t  state;
  apset_pkg::action_t act;
  apset_pkg::action_t act_in;

  logic [SRC_W-1:0]   src;
  logic [KEY_W-1:0]   key;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic               pend;
  logic [SOURCES-1:0] shown_valid;

  logic               accept;
  logic               in_range;
  logic [SRC_W-1:0]   src_in;

  logic               shown_we;
  logic [ITEM_W-1:0]  shown_rdata;
  logic [ITEM_W-1:0]  shown_cur;

  logic               rd_en;
  logic               hit;
  logic               scan_end;
  logic               room;
  logic               key_we;
  logic [KEY_W-1:0]   key_rdata;

  assign act_in   = apset_pkg::action_t'(action);
  assign accept   = start && !busy;
  assign in_range = 32'(source) < SOURCES;
  assign src_in   = source[SRC_W-1:0];
  assign busy     = (state != apset_pkg::ST_IDLE);

  // A record to an in-range row goes straight into the shown table.
  assign shown_we = accept && (act_in == apset_pkg::ACT_RECORD) && in_range;

  // The shown table is read at the command's row on every cycle; an answer
  // uses the data in the cycle after its transfer.
  apset_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(SOURCES),
    .AW   (SRC_W)
  ) u_shown (
    .clk  (clk),
    .we   (shown_we),
    .waddr(src_in),
    .wdata(item),
    .raddr(src_in),
    .rdata(shown_rdata)
  );

  // A row whose valid bit is clear has been absent since reset or the last clear.
  assign shown_cur = shown_valid[src] ? shown_rdata : ABSENT;

  // Scan: one key read is issued per cycle while entries remain, and the key
  // read in the previous cycle is compared against the target.
  assign rd_en    = (state == apset_pkg::ST_SCAN) && (idx < count);
  assign hit      = (state == apset_pkg::ST_SCAN) && pend && (key_rdata == key);
  assign scan_end = (state == apset_pkg::ST_SCAN) && (hit || (!rd_en && !pend));
  assign room     = count < FULL;
  assign key_we   = scan_end && !hit && (act == apset_pkg::ACT_ANSWER) && room;

  apset_ram #(
    .WIDTH(KEY_W),
    .DEPTH(SET_DEPTH),
    .AW   (SET_AW)
  ) u_keys (
    .clk  (clk),
    .we   (key_we),
    .waddr(count[SET_AW-1:0]),
    .wdata(key),
    .raddr(idx[SET_AW-1:0]),
    .rdata(key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= apset_pkg::ST_IDLE;
      count       <= '0;
      shown_valid <= '0;
      done        <= 1'b0;
      pend        <= 1'b0;
      idx         <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        apset_pkg::ST_IDLE: begin
          if (accept) begin
            act  <= act_in;
            src  <= src_in;
            key  <= {src_in, item};
            idx  <= '0;
            pend <= 1'b0;
            case (act_in)
              apset_pkg::ACT_RECORD: begin
                if (in_range) begin
                  shown_valid[src_in] <= 1'b1;
                end
                done <= 1'b1;
                flag <= 1'b0;
              end
              apset_pkg::ACT_QUERY: begin
                if (in_range) begin
                  state <= apset_pkg::ST_SCAN;
                end else begin
                  done <= 1'b1;
                  flag <= 1'b0;
                end
              end
              apset_pkg::ACT_ANSWER: begin
                if (in_range) begin
                  state <= apset_pkg::ST_SHOWN;
                end else begin
                  done <= 1'b1;
                  flag <= 1'b0;
                end
              end
              default: begin
                count       <= '0;
                shown_valid <= '0;
                done        <= 1'b1;
                flag        <= 1'b0;
              end
            endcase
          end
        end
        apset_pkg::ST_SHOWN: begin
          if (shown_cur == ABSENT) begin
            done  <= 1'b1;
            flag  <= 1'b0;
            state <= apset_pkg::ST_IDLE;
          end else begin
            key   <= {src, shown_cur};
            state <= apset_pkg::ST_SCAN;
          end
        end
        apset_pkg::ST_SCAN: begin
          pend <= rd_en;
          if (rd_en) begin
            idx <= idx + 1'b1;
          end
          if (scan_end) begin
            done  <= 1'b1;
            state <= apset_pkg::ST_IDLE;
            if (act == apset_pkg::ACT_ANSWER) begin
              flag <= hit || room;
              if (key_we) begin
                count <= count + 1'b1;
              end
            end else begin
              flag <= hit;
            end
          end
        end
        default: begin
          state <= apset_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/apset_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used by answered_pair_set_top.sv for the shown table and the key set.
`timescale 1ns / 1ps
`default_nettype none

module apset_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
